// File: hw/rtl/qte_pkg.sv
`default_nettype none

package qte_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int COMPONENT_WIDTH = 16;

  localparam int NSTAGES    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int FRAC       = 30;
  localparam int PW         = 32;
  localparam int TW         = 34;
  localparam int SQ_STEPS   = 31;
  localparam int SQW        = 62;
  localparam int CDW        = 38;
  localparam int AW         = 33;
  localparam int MW         = 50;
  localparam int CENTW      = 18;
  localparam int BACK_DEPTH = NSTAGES + 36;

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [PW-1:0] t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
  } qte_terms_t;

  function automatic logic signed [AW-1:0] qte_atan(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0:       r = AW'(32'h20000000);
      1:       r = AW'(32'h12E4051E);
      2:       r = AW'(32'h09FB385B);
      3:       r = AW'(32'h051111D4);
      4:       r = AW'(32'h028B0D43);
      5:       r = AW'(32'h0145D7E1);
      6:       r = AW'(32'h00A2F61E);
      7:       r = AW'(32'h00517C55);
      8:       r = AW'(32'h0028BE53);
      9:       r = AW'(32'h00145F2F);
      10:      r = AW'(32'h000A2F98);
      11:      r = AW'(32'h000517CC);
      12:      r = AW'(32'h00028BE6);
      13:      r = AW'(32'h000145F3);
      14:      r = AW'(32'h0000A2F9);
      15:      r = AW'(32'h0000517C);
      16:      r = AW'(32'h000028BE);
      17:      r = AW'(32'h0000145F);
      18:      r = AW'(32'h00000A2F);
      19:      r = AW'(32'h00000517);
      20:      r = AW'(32'h0000028B);
      21:      r = AW'(32'h00000145);
      22:      r = AW'(32'h000000A2);
      23:      r = AW'(32'h00000051);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qte_front.sv
`default_nettype none

module qte_front import qte_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic signed [15:0]   quat_x_i,
  input  wire logic signed [15:0]   quat_y_i,
  input  wire logic signed [15:0]   quat_z_i,
  input  wire logic signed [15:0]   quat_w_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output qte_terms_t                q_terms_o
);

  localparam int CW = COMPONENT_WIDTH;
  localparam logic signed [TW-1:0] ONE  = TW'(1) <<< FRAC;
  localparam logic signed [TW-1:0] MONE = -ONE;

  function automatic logic signed [CW-1:0] load_comp(input logic signed [15:0] r);
    logic signed [47:0] e;
    e = 48'(r) <<< 16;
    return CW'(e >>> (32 - CW));
  endfunction

  function automatic logic signed [PW-1:0] mul_fix(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    logic signed [71:0] p;
    p = a * b;
    p = p <<< 8;
    return PW'(p >>> (2 * CW - 24));
  endfunction

  logic v_q;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  logic signed [CW-1:0] x, y, z, w;
  logic signed [TW-1:0] t2_raw;

  assign x = load_comp(quat_x_i);
  assign y = load_comp(quat_y_i);
  assign z = load_comp(quat_z_i);
  assign w = load_comp(quat_w_i);

  assign s_ready_o = !v_q || q_ready_i;
  assign q_valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (s_ready_o) begin
      v_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      wx_q <= mul_fix(w, x);
      yz_q <= mul_fix(y, z);
      xx_q <= mul_fix(x, x);
      yy_q <= mul_fix(y, y);
      wy_q <= mul_fix(w, y);
      zx_q <= mul_fix(z, x);
      wz_q <= mul_fix(w, z);
      xy_q <= mul_fix(x, y);
      zz_q <= mul_fix(z, z);
    end
  end

  assign t2_raw = (TW'(wy_q) - TW'(zx_q)) <<< 1;

  always_comb begin
    q_terms_o.t0 = (TW'(wx_q) + TW'(yz_q)) <<< 1;
    q_terms_o.t1 = ONE - ((TW'(xx_q) + TW'(yy_q)) <<< 1);
    q_terms_o.t3 = (TW'(wz_q) + TW'(xy_q)) <<< 1;
    q_terms_o.t4 = ONE - ((TW'(yy_q) + TW'(zz_q)) <<< 1);
    if (t2_raw > ONE) begin
      q_terms_o.t2 = PW'(ONE);
    end else if (t2_raw < MONE) begin
      q_terms_o.t2 = PW'(MONE);
    end else begin
      q_terms_o.t2 = PW'(t2_raw);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qte_fifo.sv
`default_nettype none

module qte_fifo import qte_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        w_valid_i,
  output logic             w_ready_o,
  input  wire qte_terms_t  w_data_i,
  output logic             r_valid_o,
  input  wire logic        r_ready_i,
  output qte_terms_t       r_data_o
);

  qte_terms_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign w_ready_o = (cnt_q != 2'd2);
  assign r_valid_o = (cnt_q != 2'd0);
  assign r_data_o  = mem_q[rptr_q];
  assign push      = w_valid_i && w_ready_o;
  assign pop       = r_valid_o && r_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= w_data_i;
  end

endmodule

`default_nettype wire

// File: hw/rtl/qte_cordic.sv
`default_nettype none

module qte_cordic import qte_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [TW-1:0]    x_i,
  input  wire logic signed [TW-1:0]    y_i,
  output logic signed [CENTW-1:0]      cent_o
);

  localparam logic signed [AW-1:0] QUARTER = AW'(32'h40000000);
  localparam logic signed [MW-1:0] CENT    = MW'(36000);
  localparam logic signed [MW-1:0] HALF    = MW'(1) <<< 31;

  logic signed [CDW-1:0] x_q [NSTAGES+1];
  logic signed [CDW-1:0] y_q [NSTAGES+1];
  logic signed [AW-1:0]  a_q [NSTAGES+1];
  logic                  z_q [NSTAGES+1];
  logic signed [MW-1:0]  m_q;
  logic signed [CDW-1:0] xe, ye;

  assign xe = CDW'(x_i);
  assign ye = CDW'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (x_i == '0) && (y_i == '0);
      if (xe < 0) begin
        if (ye >= 0) begin
          x_q[0] <= ye;
          y_q[0] <= -xe;
          a_q[0] <= QUARTER;
        end else begin
          x_q[0] <= -ye;
          y_q[0] <= xe;
          a_q[0] <= -QUARTER;
        end
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1] <= z_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] + qte_atan(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] - qte_atan(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= z_q[NSTAGES] ? '0 : MW'(a_q[NSTAGES]) * CENT;
    end
  end

  assign cent_o = CENTW'((m_q + HALF) >>> 32);

endmodule

`default_nettype wire

// File: hw/rtl/qte_back.sv
`default_nettype none

module qte_back import qte_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  output logic                     q_ready_o,
  input  wire qte_terms_t          q_terms_i,
  output logic                     m_valid_o,
  input  wire logic                m_ready_i,
  output logic signed [15:0]       roll_o,
  output logic signed [14:0]       pitch_o,
  output logic signed [15:0]       yaw_o
);

  localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * FRAC);

  function automatic logic signed [CENTW-1:0] clamp(input logic signed [CENTW-1:0] c,
                                                   input logic signed [CENTW-1:0] lim);
    if (c > lim) return lim;
    if (c < -lim) return -lim;
    return c;
  endfunction

  logic [BACK_DEPTH-1:0] v_q;
  logic                  adv;
  qte_terms_t            terms_q [SQ_STEPS+2];
  logic signed [63:0]    tsq_q;
  logic [SQW-1:0]        n_q   [SQ_STEPS+1];
  logic [SQW-1:0]        res_q [SQ_STEPS+1];
  logic signed [CENTW-1:0] c_roll, c_pitch, c_yaw;
  logic signed [15:0]    roll_q, yaw_q;
  logic signed [14:0]    pitch_q;
  logic signed [TW-1:0]  pitch_x;

  assign adv       = !v_q[BACK_DEPTH-1] || m_ready_i;
  assign q_ready_o = adv;
  assign m_valid_o = v_q[BACK_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[BACK_DEPTH-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      terms_q[0] <= q_terms_i;
      tsq_q      <= q_terms_i.t2 * q_terms_i.t2;
      terms_q[1] <= terms_q[0];
      n_q[0]     <= ONE_SQ - SQW'(tsq_q);
      res_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (60 - 2 * k);
    logic [SQW-1:0] trial;
    assign trial = res_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        terms_q[k+2] <= terms_q[k+1];
        if (n_q[k] >= trial) begin
          n_q[k+1]   <= n_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + BIT;
        end else begin
          n_q[k+1]   <= n_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign pitch_x = TW'({1'b0, res_q[SQ_STEPS][30:0]});

  qte_cordic u_roll (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (terms_q[SQ_STEPS+1].t1),
    .y_i    (terms_q[SQ_STEPS+1].t0),
    .cent_o (c_roll)
  );

  qte_cordic u_pitch (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (pitch_x),
    .y_i    (TW'(terms_q[SQ_STEPS+1].t2)),
    .cent_o (c_pitch)
  );

  qte_cordic u_yaw (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (terms_q[SQ_STEPS+1].t4),
    .y_i    (terms_q[SQ_STEPS+1].t3),
    .cent_o (c_yaw)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= 16'(clamp(c_roll, CENTW'(18000)));
      pitch_q <= 15'(clamp(c_pitch, CENTW'(9000)));
      yaw_q   <= 16'(clamp(c_yaw, CENTW'(18000)));
    end
  end

  assign roll_o  = roll_q;
  assign pitch_o = pitch_q;
  assign yaw_o   = yaw_q;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_to_euler_angles.sv
// Throughput: one word per cycle; the pipelined square root and the three
// CORDIC pipelines each take a new word every cycle while the output is taken.
// A two-word queue parts the product front from the angle back end.
// Reset: rst_ni asynchronous, active low; clears all valid flags, no pass needed.
`default_nettype none

module quaternion_to_euler_angles import qte_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

  logic               f_valid, f_ready;
  qte_terms_t         f_terms;
  logic               b_valid, b_ready;
  qte_terms_t         b_terms;
  logic signed [15:0] roll, yaw;
  logic signed [14:0] pitch;

  qte_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .quat_x_i  (s_axis_tdata[15:0]),
    .quat_y_i  (s_axis_tdata[31:16]),
    .quat_z_i  (s_axis_tdata[47:32]),
    .quat_w_i  (s_axis_tdata[63:48]),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_terms_o (f_terms)
  );

  qte_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .w_valid_i (f_valid),
    .w_ready_o (f_ready),
    .w_data_i  (f_terms),
    .r_valid_o (b_valid),
    .r_ready_i (b_ready),
    .r_data_o  (b_terms)
  );

  qte_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (b_valid),
    .q_ready_o (b_ready),
    .q_terms_i (b_terms),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .roll_o    (roll),
    .pitch_o   (pitch),
    .yaw_o     (yaw)
  );

  assign m_axis_tdata = {1'b0, yaw, pitch, roll};

endmodule

`default_nettype wire
